// ----- hw/rtl/usd_pkg.sv -----
// Shared types and constants for the UTF-8 stream decoder.
package usd_pkg;

   localparam int QueueDepth    = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
   localparam logic [7:0]  ASCII_END   = 8'h80;
   localparam logic [7:0]  CONT_LOW    = 8'h80;
   localparam logic [7:0]  CONT_HIGH   = 8'hBF;
   localparam logic [7:0]  LEAD2_MIN   = 8'hC2;
   localparam logic [7:0]  LEAD2_MAX   = 8'hDF;
   localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
   localparam logic [7:0]  LEAD3_MAX   = 8'hEF;
   localparam logic [7:0]  LEAD4_MIN   = 8'hF0;
   localparam logic [7:0]  LEAD4_MAX   = 8'hF4;
   localparam logic [7:0]  LEAD_E0     = 8'hE0;
   localparam logic [7:0]  LEAD_ED     = 8'hED;
   localparam logic [7:0]  LEAD_F0     = 8'hF0;
   localparam logic [7:0]  LEAD_F4     = 8'hF4;
   localparam logic [7:0]  E0_LOW      = 8'hA0;
   localparam logic [7:0]  ED_HIGH     = 8'h9F;
   localparam logic [7:0]  F0_LOW      = 8'h90;
   localparam logic [7:0]  F4_HIGH     = 8'h8F;

   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  byte_count;
      logic        malformed;
   } result_type;

   typedef struct packed {
      logic       two;
      logic       eos;
      result_type res0;
      result_type res1;
   } entry_type;

endpackage

// ----- hw/rtl/usd_front.sv -----
// Front end: takes bytes, tracks the pending sequence and forms result entries.
module usd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   input  logic               req_end_of_stream,
   input  logic               q_full,
   output logic               q_push,
   output usd_pkg::entry_type q_entry
);
   import usd_pkg::*;

   typedef enum logic [1:0] {
      LEAD_ASCII = 2'd0,
      LEAD_BAD   = 2'd1,
      LEAD_START = 2'd2
   } lead_kind_type;

   logic [1:0]  rem_ff, rem_in;
   logic [14:0] part_ff, part_in;
   logic [1:0]  taken_ff, taken_in;
   logic [7:0]  lo_ff, lo_in;
   logic [7:0]  hi_ff, hi_in;

   lead_kind_type lead_kind;
   logic [1:0]    lead_rem;
   logic [14:0]   lead_part;
   logic [7:0]    lead_lo;
   logic [7:0]    lead_hi;

   logic        accept;
   logic        in_range;
   logic        take_lead;
   logic [20:0] cont_value;
   logic        e1_v, e2_v, e3_v;
   result_type  e1, e2, e3;

   assign req_stall  = q_full;
   assign accept     = req_valid & ~q_full;
   assign in_range   = (req_in_byte >= lo_ff) && (req_in_byte <= hi_ff);
   assign cont_value = {part_ff, req_in_byte[5:0]};

   always_comb begin
      lead_kind = LEAD_BAD;
      lead_rem  = 2'd0;
      lead_part = '0;
      lead_lo   = CONT_LOW;
      lead_hi   = CONT_HIGH;
      if (req_in_byte < ASCII_END) begin
         lead_kind = LEAD_ASCII;
      end else if (req_in_byte >= LEAD2_MIN && req_in_byte <= LEAD2_MAX) begin
         lead_kind = LEAD_START;
         lead_rem  = 2'd1;
         lead_part = {10'd0, req_in_byte[4:0]};
      end else if (req_in_byte >= LEAD3_MIN && req_in_byte <= LEAD3_MAX) begin
         lead_kind = LEAD_START;
         lead_rem  = 2'd2;
         lead_part = {11'd0, req_in_byte[3:0]};
         if (req_in_byte == LEAD_E0) lead_lo = E0_LOW;
         if (req_in_byte == LEAD_ED) lead_hi = ED_HIGH;
      end else if (req_in_byte >= LEAD4_MIN && req_in_byte <= LEAD4_MAX) begin
         lead_kind = LEAD_START;
         lead_rem  = 2'd3;
         lead_part = {12'd0, req_in_byte[2:0]};
         if (req_in_byte == LEAD_F0) lead_lo = F0_LOW;
         if (req_in_byte == LEAD_F4) lead_hi = F4_HIGH;
      end
   end

   always_comb begin
      rem_in    = rem_ff;
      part_in   = part_ff;
      taken_in  = taken_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      take_lead = 1'b1;
      e1_v      = 1'b0;
      e2_v      = 1'b0;
      e3_v      = 1'b0;
      e1        = '{code_point: REPLACEMENT, byte_count: {1'b0, taken_ff}, malformed: 1'b1};
      e2        = '{code_point: REPLACEMENT, byte_count: 3'd1, malformed: 1'b1};
      e3        = '{code_point: REPLACEMENT, byte_count: 3'd1, malformed: 1'b1};
      q_entry   = '0;

      if (rem_ff != 2'd0) begin
         if (in_range) begin
            take_lead = 1'b0;
            rem_in    = rem_ff - 2'd1;
            lo_in     = CONT_LOW;
            hi_in     = CONT_HIGH;
            if (rem_ff == 2'd1) begin
               e1_v     = 1'b1;
               e1       = '{code_point: cont_value,
                            byte_count: {1'b0, taken_ff} + 3'd1,
                            malformed: 1'b0};
               part_in  = '0;
               taken_in = 2'd0;
            end else begin
               part_in  = cont_value[14:0];
               taken_in = taken_ff + 2'd1;
            end
         end else begin
            e1_v     = 1'b1;
            rem_in   = 2'd0;
            part_in  = '0;
            taken_in = 2'd0;
            lo_in    = CONT_LOW;
            hi_in    = CONT_HIGH;
         end
      end

      if (take_lead) begin
         unique case (lead_kind)
            LEAD_ASCII: begin
               e2_v = 1'b1;
               e2   = '{code_point: {13'd0, req_in_byte}, byte_count: 3'd1, malformed: 1'b0};
            end
            LEAD_START: begin
               rem_in   = lead_rem;
               part_in  = lead_part;
               taken_in = 2'd1;
               lo_in    = lead_lo;
               hi_in    = lead_hi;
            end
            default: begin
               e2_v = 1'b1;
            end
         endcase
      end

      if (req_end_of_stream && rem_in != 2'd0) begin
         e3_v     = 1'b1;
         e3       = '{code_point: REPLACEMENT, byte_count: {1'b0, taken_in}, malformed: 1'b1};
         rem_in   = 2'd0;
         part_in  = '0;
         taken_in = 2'd0;
         lo_in    = CONT_LOW;
         hi_in    = CONT_HIGH;
      end

      q_entry.eos = req_end_of_stream;
      if (e1_v) begin
         q_entry.res0 = e1;
         q_entry.res1 = e2_v ? e2 : e3;
         q_entry.two  = e2_v | e3_v;
      end else begin
         q_entry.res0 = e2_v ? e2 : e3;
         q_entry.res1 = e3;
         q_entry.two  = 1'b0;
      end
   end

   assign q_push = accept & (e1_v | e2_v | e3_v);

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= 2'd0;
         part_ff  <= '0;
         taken_ff <= 2'd0;
         lo_ff    <= CONT_LOW;
         hi_ff    <= CONT_HIGH;
      end else if (accept) begin
         rem_ff   <= rem_in;
         part_ff  <= part_in;
         taken_ff <= taken_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
      end
   end

endmodule

// ----- hw/rtl/usd_queue.sv -----
// Short queue of result entries between the front and back ends.
module usd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  usd_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output usd_pkg::entry_type head_entry
);
   import usd_pkg::*;

   entry_type                  store_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0]   count_ff, count_in;

   assign full       = (count_ff == QueueCntWidth'(QueueDepth));
   assign not_empty  = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QueuePtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QueuePtrWidth'(1) : rd_ptr_ff;
      count_in  = count_ff + QueueCntWidth'(push) - QueueCntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == QueueCntWidth'($past(count_ff)
         + QueueCntWidth'($past(push)) - QueueCntWidth'($past(pop))))
      else $error("queue count out of step with pushes and pops");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      QueuePtrWidth'(wr_ptr_ff - rd_ptr_ff) == QueuePtrWidth'(count_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

// ----- hw/rtl/usd_back.sv -----
// Back end: drains queue entries and presents one result beat per cycle while rsp_stall is low.
module usd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  usd_pkg::entry_type q_entry,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [20:0]        rsp_code_point,
   output logic [2:0]         rsp_byte_count,
   output logic               rsp_malformed,
   output logic               rsp_run_last,
   output logic               rsp_stream_last
);
   import usd_pkg::*;

   entry_type  cur_ff;
   logic       busy_ff, busy_in;
   logic       phase_ff, phase_in;
   logic       last_beat;
   logic       beat_done;
   result_type shown;

   assign last_beat = ~cur_ff.two | phase_ff;
   assign beat_done = busy_ff & ~rsp_stall;
   assign q_pop     = q_not_empty & (~busy_ff | (beat_done & last_beat));
   assign shown     = phase_ff ? cur_ff.res1 : cur_ff.res0;

   assign rsp_valid       = busy_ff;
   assign rsp_code_point  = shown.code_point;
   assign rsp_byte_count  = shown.byte_count;
   assign rsp_malformed   = shown.malformed;
   assign rsp_run_last    = last_beat;
   assign rsp_stream_last = last_beat & cur_ff.eos;

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      if (q_pop) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
      end else if (beat_done) begin
         if (last_beat) begin
            busy_in  = 1'b0;
            phase_in = 1'b0;
         end else begin
            phase_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// ----- hw/rtl/utf8_stream_decoder.sv -----
// Top level of the streaming UTF-8 decoder.
//
//   channel   direction  handshake            beat
//   req_      in         req_valid/req_stall  one byte and end-of-stream flag
//   rsp_      out        rsp_valid/rsp_stall  one code point with count and flags
//
// A byte is taken every cycle while the four-entry result queue has room.
// Each byte yields zero, one or two result beats; the back end sends one per cycle while rsp_stall is low.
// A byte's first result beat is registered in the queue and then in the back end before it is shown.
// Reset is synchronous and clears the pending sequence, the queue and the output.
// rsp_stall holds the output beat; req_stall rises only once the queue fills.
module utf8_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [20:0] rsp_code_point,
   output logic [2:0]  rsp_byte_count,
   output logic        rsp_malformed,
   output logic        rsp_run_last,
   output logic        rsp_stream_last
);
   import usd_pkg::*;

   logic      q_full;
   logic      q_push;
   logic      q_pop;
   logic      q_not_empty;
   entry_type push_entry;
   entry_type head_entry;

   usd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_entry           (push_entry)
   );

   usd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head_entry (head_entry)
   );

   usd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_not_empty     (q_not_empty),
      .q_entry         (head_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_malformed   (rsp_malformed),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_last (rsp_stream_last)
   );

endmodule
